/* src/hte_pkg.sv */
// Shared types and constants for the table-driven Huffman encoder.
`timescale 1ns / 1ps
`default_nettype none
package hte_pkg;

	localparam int SYM_W      = 8;
	localparam int CODE_W     = 16;
	localparam int LEN_W      = 5;
	localparam int BYTE_W     = 8;
	localparam int TOTAL_W    = 32;
	localparam int TBL_DEPTH  = 256;
	localparam int ENTRY_W    = CODE_W + LEN_W;
	localparam int WIN_W      = 24;
	localparam int OQ_DEPTH   = 4;
	localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} hte_op_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               is_report;
		logic               partial_present;
		logic [TOTAL_W-1:0] symbol_total;
		logic               end_of_run;
	} hte_result_t;

endpackage
`default_nettype wire

/* src/hte_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hte_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/huffman_table_encoder_top.sv */
// Huffman encoder top level: code table RAM, bit packer and result queue.
// Input stream (s_axis): tuser carries the op (load entry, encode symbol, flush),
// tdata carries symbol, code word and code length. Loads write the code table
// RAM at the transfer; encodes read it at the transfer and are packed in stage 1,
// once the RAM data is back. Each full byte goes out as one transfer on
// m_axis; a flush gives one report transfer with the zero-padded partial byte
// and the symbol count. tlast marks the last result of an input item.
// A result passes the stage 1 register and the result queue before m_axis offers it.
// Throughput: one input item per cycle while m_axis keeps up; an encode that
// completes two bytes needs two output transfers, and a four-entry result queue
// absorbs the surplus. The packing stage only advances with two free queue
// entries, so when m_axis stalls the queue fills and s_axis tready drops.
// Reset: all code lengths read as zero (one valid flag per table entry), the
// partial byte and the symbol count are cleared and the queue is emptied.
// Code words stored in the RAM are undefined until their entry is loaded.
`timescale 1ns / 1ps
`default_nettype none
module huffman_table_encoder_top
	import hte_pkg::*;
#(
	parameter int MAX_CODE_LEN = 16,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	// [7:0] symbol, [23:8] code_bits, [28:24] code_len, [31:29] zero
	input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] op
	input  wire  [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	// [7:0] out_byte, [8] partial_present, [40:9] symbol_total, [47:41] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [0] is_report
	output logic                  m_axis_tuser,
	output logic                  m_axis_tlast
);

	localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	// input fields
	logic [SYM_W-1:0]  in_symbol;
	logic [CODE_W-1:0] in_code;
	logic [LEN_W-1:0]  in_len;
	logic [LEN_W-1:0]  in_len_clamped;
	hte_op_t           in_op;
	logic              s_accept;

	assign in_symbol      = s_axis_tdata[SYM_W-1:0];
	assign in_code        = s_axis_tdata[SYM_W+CODE_W-1:SYM_W];
	assign in_len         = s_axis_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];
	assign in_op          = hte_op_t'(s_axis_tuser);
	assign in_len_clamped = (in_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : in_len;
	assign s_accept       = s_axis_tvalid && s_axis_tready;

	// code table
	logic               tbl_we;
	logic [ENTRY_W-1:0] tbl_rdata;
	logic [TBL_DEPTH-1:0] entry_ok_q;

	assign tbl_we = s_accept && (in_op == OP_LOAD);

	hte_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TBL_DEPTH)
	) u_code_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (in_symbol),
		.wdata ({in_len_clamped, in_code}),
		.re    (s_accept),
		.raddr (in_symbol),
		.rdata (tbl_rdata)
	);

	// stage 1 and packer state
	logic                   busy_s1;
	hte_op_t                op_s1;
	logic                   entry_ok_s1;
	logic                   s1_go;
	logic                   s1_fire;
	logic [BYTE_W-2:0]      pend_bits_q;
	logic [2:0]             pend_cnt_q;
	logic [COUNT_WIDTH-1:0] sym_cnt_q;

	// result queue
	hte_result_t         oq_mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;
	logic                pop;
	logic [1:0]          push_n;
	hte_result_t         res0;
	hte_result_t         res1;

	assign pop     = m_axis_tvalid && m_axis_tready;
	assign s1_go   = (oq_cnt_q < OQ_CNT_W'(OQ_DEPTH - 1)) ||
	                 ((oq_cnt_q == OQ_CNT_W'(OQ_DEPTH - 1)) && pop);
	assign s1_fire = busy_s1 && s1_go;
	assign s_axis_tready = !busy_s1 || s1_go;

	// bit packing window: pending bits on top, new code just below them
	logic [LEN_W-1:0]  len_eff;
	logic [CODE_W-1:0] code_m;
	logic [LEN_W-1:0]  bit_sum;
	logic [LEN_W-1:0]  shamt;
	logic [WIN_W-1:0]  win;
	logic [1:0]        nbytes;
	logic [BYTE_W-2:0] new_pend;
	logic [TOTAL_W-1:0] total32;

	assign len_eff = entry_ok_s1 ? tbl_rdata[ENTRY_W-1:CODE_W] : '0;
	assign code_m  = tbl_rdata[CODE_W-1:0] & ~({CODE_W{1'b1}} << len_eff);
	assign bit_sum = {2'b00, pend_cnt_q} + len_eff;
	assign shamt   = LEN_W'(WIN_W) - bit_sum;
	assign win     = {pend_bits_q, 1'b0, {(WIN_W-BYTE_W){1'b0}}} |
	                 ({{(WIN_W-CODE_W){1'b0}}, code_m} << shamt);
	assign nbytes  = bit_sum[4:3];

	always_comb begin
		case (nbytes)
			2'd0:    new_pend = win[WIN_W-1:WIN_W-7];
			2'd1:    new_pend = win[WIN_W-9:WIN_W-15];
			default: new_pend = win[WIN_W-17:WIN_W-23];
		endcase
	end

	generate
		if (COUNT_WIDTH > TOTAL_W) begin : g_total_sat
			assign total32 = (|sym_cnt_q[COUNT_WIDTH-1:TOTAL_W]) ? '1 :
			                 sym_cnt_q[TOTAL_W-1:0];
		end else begin : g_total_ext
			assign total32 = TOTAL_W'(sym_cnt_q);
		end
	endgenerate

	always_comb begin
		res0   = '0;
		res1   = '0;
		push_n = 2'd0;
		if (s1_fire) begin
			case (op_s1)
				OP_ENCODE: begin
					push_n          = nbytes;
					res0.out_byte   = win[WIN_W-1:WIN_W-8];
					res0.end_of_run = (nbytes == 2'd1);
					res1.out_byte   = win[WIN_W-9:WIN_W-16];
					res1.end_of_run = 1'b1;
				end
				OP_FLUSH: begin
					push_n               = 2'd1;
					res0.out_byte        = (pend_cnt_q != 3'd0) ? {pend_bits_q, 1'b0} : '0;
					res0.is_report       = 1'b1;
					res0.partial_present = (pend_cnt_q != 3'd0);
					res0.symbol_total    = total32;
					res0.end_of_run      = 1'b1;
				end
				default: begin
					push_n = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_ok_q  <= '0;
			busy_s1     <= 1'b0;
			op_s1       <= OP_LOAD;
			entry_ok_s1 <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			sym_cnt_q   <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			oq_cnt_q    <= '0;
		end else begin
			if (tbl_we) begin
				entry_ok_q[in_symbol] <= 1'b1;
			end
			if (s_accept) begin
				busy_s1     <= 1'b1;
				op_s1       <= in_op;
				entry_ok_s1 <= entry_ok_q[in_symbol];
			end else if (s1_go) begin
				busy_s1 <= 1'b0;
			end
			if (s1_fire && op_s1 == OP_ENCODE) begin
				pend_bits_q <= new_pend;
				pend_cnt_q  <= bit_sum[2:0];
				if (sym_cnt_q != '1) begin
					sym_cnt_q <= sym_cnt_q + COUNT_WIDTH'(1);
				end
			end else if (s1_fire && op_s1 == OP_FLUSH) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
				sym_cnt_q   <= '0;
			end
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			oq_mem_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			oq_mem_q[wr_ptr_q + OQ_PTR_W'(1)] <= res1;
		end
	end

	hte_result_t head;

	assign head          = oq_mem_q[rd_ptr_q];
	assign m_axis_tvalid = (oq_cnt_q != '0);
	assign m_axis_tdata  = {{(OUT_DATA_W-BYTE_W-1-TOTAL_W){1'b0}}, head.symbol_total,
	                        head.partial_present, head.out_byte};
	assign m_axis_tuser  = head.is_report;
	assign m_axis_tlast  = head.end_of_run;

	// queue never overfills, even with a two-byte encode
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue overflow");

	// a stalled packing stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && !s1_go |=> busy_s1 && $stable(op_s1) && $stable(entry_ok_s1))
		else $error("stage 1 item lost while stalled");

	// every input transfer reaches the packing stage next cycle
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> busy_s1)
		else $error("accepted item missing from stage 1");

	// a flush leaves the packer empty
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && op_s1 == OP_FLUSH |=> pend_cnt_q == '0 && sym_cnt_q == '0)
		else $error("flush did not clear packer state");

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the table-driven Huffman encoder and byte packer.
`timescale 1ns / 1ps
module tb;
	import hte_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 6;
	localparam int MAX_CODE_LEN = 16;
	localparam int COUNT_WIDTH  = 32;
	localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int N_RANDOM     = 1430;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_PCT     = 35;
	localparam int USE_MODEL    = -1;
	localparam int DIR_DEPTH    = 32;
	localparam int KNOWN_DEPTH  = N_RANDOM + 16;
	localparam int DUE_DEPTH    = 2 * (N_RANDOM + 64);
	localparam int N_DIR_SYMS   = 7;
	localparam logic [SYM_W-1:0] DIR_SYMS [N_DIR_SYMS] =
		'{8'h00, 8'hFF, 8'h41, 8'h7F, 8'h22, 8'h10, 8'h01};
	// the op code left undefined by the block; it must be swallowed silently
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]        op;
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		int                n_typed;
		hte_result_t       typed_res;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [1:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	// predictor state
	logic [CODE_W-1:0]      tbl_code [TBL_DEPTH];
	logic [LEN_W-1:0]       tbl_len  [TBL_DEPTH];
	logic [6:0]             pend_bits;
	int                     pend_cnt;
	logic [COUNT_WIDTH-1:0] sym_count;
	hte_result_t            pred_res [2];
	int                     pred_n;

	// expected results in order: written at due_wr, consumed at due_rd
	hte_result_t    due_results [DUE_DEPTH];
	int             due_wr;
	int             due_rd;
	hte_result_t    got;
	hte_result_t    want;
	logic [SYM_W-1:0] known_syms [KNOWN_DEPTH];
	int             n_known;
	dir_row_t       dir_tbl [DIR_DEPTH];
	int             n_dir;
	bit             quiet;
	int             errors;
	int             n_checked;
	int             n_reports;
	int             n_loads;
	int             n_encodes;
	int             n_flushes;
	int             n_ignored;
	int             idle_cycles;

	huffman_table_encoder_top #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	// Works out the results of one item and advances the predictor state.
	task automatic huff_predict(input logic [1:0] op, input logic [SYM_W-1:0] sym,
		input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		logic [7:0] acc;
		int         cnt;
		pred_n = 0;
		case (op)
			OP_LOAD: begin
				tbl_code[sym] = code;
				tbl_len[sym]  = (len > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
			end
			OP_ENCODE: begin
				acc = {pend_bits, 1'b0};
				cnt = pend_cnt;
				for (int i = tbl_len[sym]; i > 0; i--) begin
					acc[7 - cnt] = tbl_code[sym][i - 1];
					cnt++;
					if (cnt == 8) begin
						pred_res[pred_n] = '{acc, 1'b0, 1'b0, 32'd0, 1'b0};
						pred_n++;
						acc = '0;
						cnt = 0;
					end
				end
				pend_bits = acc[7:1];
				pend_cnt  = cnt;
				if (sym_count != '1)
					sym_count++;
				if (pred_n > 0)
					pred_res[pred_n - 1].end_of_run = 1'b1;
			end
			OP_FLUSH: begin
				pred_res[0] = '{(pend_cnt != 0) ? {pend_bits, 1'b0} : 8'h00, 1'b1,
					pend_cnt != 0, sym_count[TOTAL_W-1:0], 1'b1};
				pred_n    = 1;
				pend_bits = '0;
				pend_cnt  = 0;
				sym_count = '0;
			end
			default: ;
		endcase
	endtask

	// Appends one expected result.
	task automatic due_add(input hte_result_t r);
		due_results[due_wr] = r;
		due_wr++;
	endtask

	// Offers one item, waits for its transfer and queues what it should cause.
	task automatic push_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
		input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
		input int n_typed, input hte_result_t typed_res);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {3'b000, len, code, sym};
		do
			@(posedge clk);
		while (!s_axis_tready);
		huff_predict(op, sym, code, len);
		if (n_typed == USE_MODEL) begin
			for (int k = 0; k < pred_n; k++)
				due_add(pred_res[k]);
		end else if (n_typed == 1) begin
			due_add(typed_res);
		end
		case (op)
			OP_LOAD:   n_loads++;
			OP_ENCODE: n_encodes++;
			OP_FLUSH:  n_flushes++;
			default:   n_ignored++;
		endcase
	endtask

	// Adds one row to the directed table.
	task automatic add_row(input logic [1:0] op, input logic [SYM_W-1:0] sym,
		input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
		input int n_typed, input hte_result_t typed_res);
		dir_tbl[n_dir] = '{op, sym, code, len, n_typed, typed_res};
		n_dir++;
	endtask

	// Result side: random back-pressure and in-order comparison.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[8],
					m_axis_tdata[40:9], m_axis_tlast};
				n_checked++;
				if (got.is_report)
					n_reports++;
				if (due_rd == due_wr) begin
					$error("unexpected result: out_byte %0h is_report %0b", got.out_byte,
						got.is_report);
					errors = errors + 1;
				end else begin
					want = due_results[due_rd];
					due_rd++;
					if (got.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
						errors = errors + 1;
					end
					if (got.is_report !== want.is_report) begin
						$error("is_report: expected %0b, got %0b", want.is_report,
							got.is_report);
						errors = errors + 1;
					end
					if (got.partial_present !== want.partial_present) begin
						$error("partial_present: expected %0b, got %0b",
							want.partial_present, got.partial_present);
						errors = errors + 1;
					end
					if (got.symbol_total !== want.symbol_total) begin
						$error("symbol_total: expected %0d, got %0d", want.symbol_total,
							got.symbol_total);
						errors = errors + 1;
					end
					if (got.end_of_run !== want.end_of_run) begin
						$error("end_of_run: expected %0b, got %0b", want.end_of_run,
							got.end_of_run);
						errors = errors + 1;
					end
				end
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog on cycles without any transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0]        op;
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		int                roll;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		quiet         = 1'b0;
		errors        = 0;
		n_checked     = 0;
		n_reports     = 0;
		n_loads       = 0;
		n_encodes     = 0;
		n_flushes     = 0;
		n_ignored     = 0;
		idle_cycles   = 0;
		due_wr        = 0;
		due_rd        = 0;
		n_known       = 0;
		n_dir         = 0;
		pend_bits     = '0;
		pend_cnt      = 0;
		sym_count     = '0;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			tbl_code[i] = '0;
			tbl_len[i]  = '0;
		end

		// directed rows; typed results only where obvious
		add_row(OP_FLUSH,  8'h00, 16'h0000, 5'd0, 1, '{8'h00, 1'b1, 1'b0, 32'd0, 1'b1});
		add_row(OP_ENCODE, 8'h05, 16'h0000, 5'd0, 0, '0);  // unset symbol
		add_row(OP_FLUSH,  8'h00, 16'h0000, 5'd0, 1, '{8'h00, 1'b1, 1'b0, 32'd1, 1'b1});
		add_row(OP_LOAD,   8'h00, 16'hFFFF, 5'd16, 0, '0);
		add_row(OP_LOAD,   8'hFF, 16'h00A5, 5'd8, 0, '0);
		add_row(OP_ENCODE, 8'h00, 16'h0000, 5'd0, USE_MODEL, '0);
		add_row(OP_LOAD,   8'h41, 16'h0001, 5'd1, 0, '0);
		add_row(OP_ENCODE, 8'h41, 16'h0000, 5'd0, 0, '0);
		add_row(OP_FLUSH,  8'h00, 16'h0000, 5'd0, 1, '{8'h80, 1'b1, 1'b1, 32'd2, 1'b1});
		add_row(OP_LOAD,   8'h7F, 16'hFFFF, 5'd31, 0, '0); // clamped length
		add_row(OP_ENCODE, 8'h41, 16'h0000, 5'd0, USE_MODEL, '0);
		add_row(OP_ENCODE, 8'h7F, 16'h0000, 5'd0, USE_MODEL, '0);
		add_row(OP_LOAD,   8'h80, 16'h1234, 5'd0, 0, '0);  // zero length
		add_row(OP_ENCODE, 8'h80, 16'h0000, 5'd0, 0, '0);
		add_row(OP_UNUSED, 8'hFF, 16'hFFFF, 5'd31, 0, '0);
		add_row(OP_LOAD,   8'h22, 16'h0003, 5'd17, 0, '0);
		add_row(OP_ENCODE, 8'hFF, 16'h0000, 5'd0, USE_MODEL, '0);
		add_row(OP_ENCODE, 8'h22, 16'h0000, 5'd0, USE_MODEL, '0);
		add_row(OP_FLUSH,  8'h00, 16'h0000, 5'd0, USE_MODEL, '0);
		add_row(OP_FLUSH,  8'h00, 16'h0000, 5'd0, 1, '{8'h00, 1'b1, 1'b0, 32'd0, 1'b1});
		// upper code bits beyond the length must be dropped
		add_row(OP_LOAD,   8'h10, 16'hFFF5, 5'd3, 0, '0);
		add_row(OP_ENCODE, 8'h10, 16'h0000, 5'd0, USE_MODEL, '0);
		add_row(OP_ENCODE, 8'h7F, 16'h0000, 5'd0, USE_MODEL, '0);
		add_row(OP_LOAD,   8'h01, 16'h0000, 5'd16, 0, '0);
		add_row(OP_ENCODE, 8'h01, 16'h0000, 5'd0, USE_MODEL, '0);
		add_row(OP_FLUSH,  8'h00, 16'h0000, 5'd0, USE_MODEL, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < n_dir; i++)
			push_item(dir_tbl[i].op, dir_tbl[i].sym, dir_tbl[i].code, dir_tbl[i].len,
				dir_tbl[i].n_typed, dir_tbl[i].typed_res);
		for (int i = 0; i < N_DIR_SYMS; i++) begin
			known_syms[n_known] = DIR_SYMS[i];
			n_known++;
		end

		// mostly encodes of loaded symbols, with table updates, flushes and unused op codes mixed in
		for (int n = 0; n < N_RANDOM; n++) begin
			quiet = (n >= 500 && n < 800);
			roll  = $urandom_range(99);
			sym   = $urandom_range(255);
			code  = $urandom_range(16'hFFFF);
			len   = $urandom_range(31);
			if (roll < 14) begin
				op   = OP_LOAD;
				roll = $urandom_range(9);
				if (roll == 0)
					len = 5'd0;
				else if (roll == 1)
					len = LEN_W'($urandom_range(31, 17));
				else
					len = LEN_W'($urandom_range(16, 1));
				known_syms[n_known] = sym;
				n_known++;
			end else if (roll < 90) begin
				op = OP_ENCODE;
				if ($urandom_range(9) < 8)
					sym = known_syms[$urandom_range(n_known - 1)];
			end else if (roll < 97) begin
				op = OP_FLUSH;
			end else begin
				op = OP_UNUSED;
			end
			push_item(op, sym, code, len, USE_MODEL, '0);
		end
		quiet = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (due_rd != due_wr)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d loads, %0d encodes, %0d flushes and %0d ignored items;",
			n_loads, n_encodes, n_flushes, n_ignored);
		$display("%0d results checked, %0d of them reports, %0d errors.",
			n_checked, n_reports, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
src/hte_pkg.sv
src/hte_ram.sv
src/huffman_table_encoder_top.sv
test/tb.sv
